@@ hdl/dsf_pkg.sv @@
// dsf_pkg: shared types, constants and saturation helpers of the damped spring follower
// depends on nothing; used by the serial units and the top level
`timescale 1ns / 1ps

package dsf_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KM,
        ST_CM,
        ST_DMUL,
        ST_VMUL,
        ST_AMUL,
        ST_SQMUL,
        ST_LIMMUL,
        ST_SQRT,
        ST_SCMUL,
        ST_SCDIV,
        ST_PMUL,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        REG_STIFFNESS   = 3'd0,
        REG_DAMPING     = 3'd1,
        REG_MASS        = 3'd2,
        REG_MAX_SPEED   = 3'd3,
        REG_GRAVITY_SAG = 3'd4,
        REG_TIME_STEP   = 3'd5
    } reg_idx_t;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;
    localparam int SQ_N_W  = 64;
    localparam int SQ_R_W  = SQ_N_W / 2;
    localparam int GAIN_FRAC = 16;

    localparam logic [31:0] MASS_FLOOR = 32'd66;
    localparam logic [31:0] RST_STIFFNESS   = 32'd65536;
    localparam logic [31:0] RST_DAMPING     = 32'd55706;
    localparam logic [31:0] RST_MASS        = 32'd65536;
    localparam logic [30:0] RST_MAX_SPEED   = 31'd614400000;
    localparam logic [30:0] RST_GRAVITY_SAG = 31'd2048;
    localparam logic [15:0] RST_TIME_STEP   = 16'd1092;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [65:0] apply_sign(input logic neg, input logic [63:0] mag);
        logic signed [65:0] m;
        m = $signed({2'b00, mag});
        return neg ? -m : m;
    endfunction

endpackage

@@ hdl/dsf_mul.sv @@
// dsf_mul: shift-add multiplier, one multiplier bit per cycle
// depends on dsf_pkg for operand widths
`timescale 1ns / 1ps

module dsf_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dsf_pkg::MUL_A_W-1:0]   a,
    input  logic [dsf_pkg::MUL_B_W-1:0]   b,
    output logic                          done,
    output logic [dsf_pkg::MUL_P_W-1:0]   p
);

    logic [dsf_pkg::MUL_A_W-1:0] a_reg;
    logic [dsf_pkg::MUL_A_W-1:0] hi_reg;
    logic [dsf_pkg::MUL_B_W-1:0] lo_reg;
    logic [4:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [dsf_pkg::MUL_A_W:0]   sum;

    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
    assign done = done_reg;
    assign p    = {hi_reg, lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                hi_reg   <= '0;
                lo_reg   <= b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                hi_reg  <= sum[dsf_pkg::MUL_A_W:1];
                lo_reg  <= {sum[0], lo_reg[dsf_pkg::MUL_B_W-1:1]};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(dsf_pkg::MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hdl/dsf_div.sv @@
// dsf_div: restoring divider, one quotient bit per cycle
// depends on dsf_pkg for operand widths
`timescale 1ns / 1ps

module dsf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dsf_pkg::DIV_N_W-1:0]   num,
    input  logic [dsf_pkg::DIV_D_W-1:0]   den,
    output logic                          done,
    output logic [dsf_pkg::DIV_N_W-1:0]   quo
);

    logic [dsf_pkg::DIV_N_W-1:0] n_reg;
    logic [dsf_pkg::DIV_D_W-1:0] d_reg;
    logic [dsf_pkg::DIV_D_W-1:0] rem_reg;
    logic [5:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [dsf_pkg::DIV_D_W:0]   shifted;
    logic [dsf_pkg::DIV_D_W:0]   diff;
    logic                        ge;

    assign shifted = {rem_reg, n_reg[dsf_pkg::DIV_N_W-1]};
    assign ge      = shifted >= {1'b0, d_reg};
    assign diff    = shifted - {1'b0, d_reg};
    assign done    = done_reg;
    assign quo     = n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg    <= num;
                d_reg    <= den;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[dsf_pkg::DIV_D_W-1:0] : shifted[dsf_pkg::DIV_D_W-1:0];
                n_reg   <= {n_reg[dsf_pkg::DIV_N_W-2:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(dsf_pkg::DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hdl/dsf_sqrt.sv @@
// dsf_sqrt: floor square root, two radicand bits per cycle
// depends on dsf_pkg for operand widths
`timescale 1ns / 1ps

module dsf_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [dsf_pkg::SQ_N_W-1:0]   rad,
    output logic                         done,
    output logic [dsf_pkg::SQ_R_W-1:0]   root
);

    logic [dsf_pkg::SQ_N_W-1:0] n_reg;
    logic [dsf_pkg::SQ_R_W:0]   rem_reg;
    logic [dsf_pkg::SQ_R_W-1:0] root_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [dsf_pkg::SQ_R_W+2:0] shifted;
    logic [dsf_pkg::SQ_R_W+2:0] trial;
    logic [dsf_pkg::SQ_R_W+2:0] diff;
    logic                       ge;

    assign shifted = {rem_reg, n_reg[dsf_pkg::SQ_N_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;
    assign done    = done_reg;
    assign root    = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg    <= rad;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[dsf_pkg::SQ_R_W:0] : shifted[dsf_pkg::SQ_R_W:0];
                root_reg <= {root_reg[dsf_pkg::SQ_R_W-2:0], ge};
                n_reg    <= {n_reg[dsf_pkg::SQ_N_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(dsf_pkg::SQ_R_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hdl/damped_spring_follower_top.sv @@
// damped_spring_follower_top: 3d spring-damper follower, one euler step per s_cmd 0 input beat
// depends on dsf_pkg, dsf_mul, dsf_div, dsf_sqrt
//
// usage
// - program gains, mass, speed limit, sag and time step over the apb port while idle;
//   registers sit at byte addresses 0,4,..,20 and read back their value
// - an input beat (s_cmd, s_target_*) is taken when s_valid and s_ready are high;
//   s_ready is high only while no step is in progress
// - s_cmd 1 snaps the position to the target (z minus sag) and goes straight to the output
// - s_cmd 0 runs one step through a shared bit-serial multiplier, divider and square
//   root; the square root and the scaling divides run only when the speed limit engages
// - the result beat (m_pos_*, m_speed_limited) waits in an output register; the next
//   input is taken while it waits, but a finished step holds until m_ready
// - reset clears position, velocity and control and loads register defaults
`timescale 1ns / 1ps

module damped_spring_follower_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic               m_speed_limited
);

    logic [31:0] stiffness_reg;
    logic [31:0] damping_reg;
    logic [31:0] mass_reg;
    logic [30:0] max_speed_reg;
    logic [30:0] gravity_sag_reg;
    logic [15:0] time_step_reg;

    dsf_pkg::state_t state_reg, state_next;

    logic signed [31:0] tgt_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic [1:0]         ax_reg;
    logic [31:0]        km_reg;
    logic [31:0]        cm_reg;
    logic signed [47:0] t1_reg;
    logic signed [48:0] acc_reg;
    logic [63:0]        sumsq_reg;
    logic [31:0]        root_reg;
    logic [63:0]        num_reg;
    logic               lim_reg;
    logic               run_reg;
    logic               m_valid_reg;
    logic signed [31:0] m_pos_x_reg, m_pos_y_reg, m_pos_z_reg;
    logic               m_lim_reg;

    logic               mul_start, div_start, sqrt_start;
    logic               mul_done, div_done, sqrt_done;
    logic [dsf_pkg::MUL_A_W-1:0] mul_a;
    logic [dsf_pkg::MUL_B_W-1:0] mul_b;
    logic [dsf_pkg::MUL_P_W-1:0] mul_p;
    logic [dsf_pkg::DIV_N_W-1:0] div_num;
    logic [dsf_pkg::DIV_D_W-1:0] div_den;
    logic [dsf_pkg::DIV_N_W-1:0] div_quo;
    logic [dsf_pkg::SQ_R_W-1:0]  sqrt_root;

    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic [31:0]        m_eff;
    logic signed [31:0] pos_cur, vel_cur, tgt_cur;
    logic signed [31:0] disp;
    logic               disp_neg, vel_neg, acc_neg;
    logic [31:0]        disp_mag, vel_mag;
    logic [47:0]        acc_mag;
    logic [63:0]        mul_lo;
    logic [47:0]        mul_shr;
    logic [1:0]         ax_wrap;
    logic               ax_last;
    logic signed [65:0] t2_full, acc_full, dv_full, dp_full;
    logic signed [31:0] pnew;

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        unique case (cfg_idx)
            dsf_pkg::REG_STIFFNESS:   prdata = stiffness_reg;
            dsf_pkg::REG_DAMPING:     prdata = damping_reg;
            dsf_pkg::REG_MASS:        prdata = mass_reg;
            dsf_pkg::REG_MAX_SPEED:   prdata = {1'b0, max_speed_reg};
            dsf_pkg::REG_GRAVITY_SAG: prdata = {1'b0, gravity_sag_reg};
            dsf_pkg::REG_TIME_STEP:   prdata = {16'd0, time_step_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiffness_reg   <= dsf_pkg::RST_STIFFNESS;
            damping_reg     <= dsf_pkg::RST_DAMPING;
            mass_reg        <= dsf_pkg::RST_MASS;
            max_speed_reg   <= dsf_pkg::RST_MAX_SPEED;
            gravity_sag_reg <= dsf_pkg::RST_GRAVITY_SAG;
            time_step_reg   <= dsf_pkg::RST_TIME_STEP;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dsf_pkg::REG_STIFFNESS:   stiffness_reg   <= pwdata;
                dsf_pkg::REG_DAMPING:     damping_reg     <= pwdata;
                dsf_pkg::REG_MASS:        mass_reg        <= pwdata;
                dsf_pkg::REG_MAX_SPEED:   max_speed_reg   <= pwdata[30:0];
                dsf_pkg::REG_GRAVITY_SAG: gravity_sag_reg <= pwdata[30:0];
                dsf_pkg::REG_TIME_STEP:   time_step_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // datapath terms
    assign m_eff    = (mass_reg < dsf_pkg::MASS_FLOOR) ? dsf_pkg::MASS_FLOOR : mass_reg;
    assign pos_cur  = pos_reg[ax_reg];
    assign vel_cur  = vel_reg[ax_reg];
    assign tgt_cur  = tgt_reg[ax_reg];
    assign disp     = dsf_pkg::sat32(66'(tgt_cur) - 66'(pos_cur));
    assign disp_neg = disp[31];
    assign vel_neg  = vel_cur[31];
    assign acc_neg  = acc_reg[48];
    assign disp_mag = disp_neg ? 32'(-disp) : 32'(disp);
    assign vel_mag  = vel_neg ? 32'(-vel_cur) : 32'(vel_cur);
    assign acc_mag  = acc_neg ? 48'(-acc_reg) : 48'(acc_reg);
    assign mul_lo   = mul_p[63:0];
    assign mul_shr  = mul_p[63:dsf_pkg::GAIN_FRAC];
    assign ax_last  = (ax_reg == 2'd2);
    assign ax_wrap  = ax_last ? 2'd0 : ax_reg + 2'd1;
    assign t2_full  = dsf_pkg::apply_sign(vel_neg, {16'd0, mul_shr});
    assign acc_full = 66'(t1_reg) - t2_full;
    assign dv_full  = dsf_pkg::apply_sign(acc_neg, {16'd0, mul_shr});
    assign dp_full  = dsf_pkg::apply_sign(vel_neg, {16'd0, mul_shr});
    assign pnew     = dsf_pkg::sat32(66'(pos_cur) + dp_full);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsf_pkg::ST_IDLE:   if (s_valid) state_next = s_cmd ? dsf_pkg::ST_OUT
                                                                : dsf_pkg::ST_KM;
            dsf_pkg::ST_KM:     if (div_done) state_next = dsf_pkg::ST_CM;
            dsf_pkg::ST_CM:     if (div_done) state_next = dsf_pkg::ST_DMUL;
            dsf_pkg::ST_DMUL:   if (mul_done) state_next = dsf_pkg::ST_VMUL;
            dsf_pkg::ST_VMUL:   if (mul_done) state_next = dsf_pkg::ST_AMUL;
            dsf_pkg::ST_AMUL:   if (mul_done) state_next = ax_last ? dsf_pkg::ST_SQMUL
                                                                   : dsf_pkg::ST_DMUL;
            dsf_pkg::ST_SQMUL: begin
                if (mul_done && ax_last) begin
                    state_next = (max_speed_reg == '0) ? dsf_pkg::ST_PMUL
                                                       : dsf_pkg::ST_LIMMUL;
                end
            end
            dsf_pkg::ST_LIMMUL: if (mul_done) state_next = (sumsq_reg > mul_lo) ? dsf_pkg::ST_SQRT
                                                                                : dsf_pkg::ST_PMUL;
            dsf_pkg::ST_SQRT:   if (sqrt_done) state_next = dsf_pkg::ST_SCMUL;
            dsf_pkg::ST_SCMUL:  if (mul_done) state_next = dsf_pkg::ST_SCDIV;
            dsf_pkg::ST_SCDIV:  if (div_done) state_next = ax_last ? dsf_pkg::ST_PMUL
                                                                   : dsf_pkg::ST_SCMUL;
            dsf_pkg::ST_PMUL:   if (mul_done && ax_last) state_next = dsf_pkg::ST_OUT;
            dsf_pkg::ST_OUT:    if (!m_valid_reg || m_ready) state_next = dsf_pkg::ST_IDLE;
            default:            state_next = dsf_pkg::ST_IDLE;
        endcase
    end

    // unit control and operand select
    always_comb begin
        s_ready    = (state_reg == dsf_pkg::ST_IDLE);
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_num    = '0;
        div_den    = m_eff;
        unique case (state_reg)
            dsf_pkg::ST_KM: begin
                div_start = !run_reg;
                div_num   = {16'd0, stiffness_reg, 16'd0};
            end
            dsf_pkg::ST_CM: begin
                div_start = !run_reg;
                div_num   = {16'd0, damping_reg, 16'd0};
            end
            dsf_pkg::ST_DMUL: begin
                mul_start = !run_reg;
                mul_a     = {16'd0, disp_mag};
                mul_b     = km_reg;
            end
            dsf_pkg::ST_VMUL: begin
                mul_start = !run_reg;
                mul_a     = {16'd0, vel_mag};
                mul_b     = cm_reg;
            end
            dsf_pkg::ST_AMUL: begin
                mul_start = !run_reg;
                mul_a     = acc_mag;
                mul_b     = {16'd0, time_step_reg};
            end
            dsf_pkg::ST_SQMUL: begin
                mul_start = !run_reg;
                mul_a     = {16'd0, vel_mag};
                mul_b     = vel_mag;
            end
            dsf_pkg::ST_LIMMUL: begin
                mul_start = !run_reg;
                mul_a     = {17'd0, max_speed_reg};
                mul_b     = {1'b0, max_speed_reg};
            end
            dsf_pkg::ST_SQRT: begin
                sqrt_start = !run_reg;
            end
            dsf_pkg::ST_SCMUL: begin
                mul_start = !run_reg;
                mul_a     = {16'd0, vel_mag};
                mul_b     = {1'b0, max_speed_reg};
            end
            dsf_pkg::ST_SCDIV: begin
                div_start = !run_reg;
                div_num   = num_reg;
                div_den   = root_reg;
            end
            dsf_pkg::ST_PMUL: begin
                mul_start = !run_reg;
                mul_a     = {16'd0, vel_mag};
                mul_b     = {16'd0, time_step_reg};
            end
            default: ;
        endcase
    end

    dsf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    dsf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    dsf_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad     (sumsq_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsf_pkg::ST_IDLE;
            run_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mul_start || div_start || sqrt_start) begin
                run_reg <= 1'b1;
            end else if (mul_done || div_done || sqrt_done) begin
                run_reg <= 1'b0;
            end
        end
    end

    // step datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg  <= '0;
            lim_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                dsf_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        tgt_reg[0] <= s_target_x;
                        tgt_reg[1] <= s_target_y;
                        tgt_reg[2] <= s_target_z;
                        ax_reg     <= '0;
                        lim_reg    <= 1'b0;
                        if (s_cmd) begin
                            pos_reg[0] <= s_target_x;
                            pos_reg[1] <= s_target_y;
                            pos_reg[2] <= dsf_pkg::sat32(66'(s_target_z)
                                                         - 66'(gravity_sag_reg));
                            for (int i = 0; i < 3; i++) begin
                                vel_reg[i] <= '0;
                            end
                        end
                    end
                end
                dsf_pkg::ST_KM: begin
                    if (div_done) begin
                        km_reg <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
                    end
                end
                dsf_pkg::ST_CM: begin
                    if (div_done) begin
                        cm_reg <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
                    end
                end
                dsf_pkg::ST_DMUL: begin
                    if (mul_done) begin
                        t1_reg <= 48'(dsf_pkg::apply_sign(disp_neg, {16'd0, mul_shr}));
                    end
                end
                dsf_pkg::ST_VMUL: begin
                    if (mul_done) begin
                        acc_reg <= acc_full[48:0];
                    end
                end
                dsf_pkg::ST_AMUL: begin
                    if (mul_done) begin
                        vel_reg[ax_reg] <= dsf_pkg::sat32(66'(vel_cur) + dv_full);
                        ax_reg          <= ax_wrap;
                        if (ax_last) begin
                            sumsq_reg <= '0;
                        end
                    end
                end
                dsf_pkg::ST_SQMUL: begin
                    if (mul_done) begin
                        sumsq_reg <= sumsq_reg + mul_lo;
                        ax_reg    <= ax_wrap;
                    end
                end
                dsf_pkg::ST_SQRT: begin
                    if (sqrt_done) begin
                        root_reg <= (sqrt_root == '0) ? 32'd1 : sqrt_root;
                        lim_reg  <= 1'b1;
                    end
                end
                dsf_pkg::ST_SCMUL: begin
                    if (mul_done) begin
                        num_reg <= mul_lo;
                    end
                end
                dsf_pkg::ST_SCDIV: begin
                    if (div_done) begin
                        vel_reg[ax_reg] <= dsf_pkg::sat32(dsf_pkg::apply_sign(vel_neg, div_quo));
                        ax_reg          <= ax_wrap;
                    end
                end
                dsf_pkg::ST_PMUL: begin
                    if (mul_done) begin
                        if (ax_last) begin
                            pos_reg[ax_reg] <= dsf_pkg::sat32(66'(pnew) - 66'(gravity_sag_reg));
                        end else begin
                            pos_reg[ax_reg] <= pnew;
                        end
                        ax_reg <= ax_wrap;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == dsf_pkg::ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
            m_pos_x_reg <= pos_reg[0];
            m_pos_y_reg <= pos_reg[1];
            m_pos_z_reg <= pos_reg[2];
            m_lim_reg   <= lim_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pos_x         = m_pos_x_reg;
    assign m_pos_y         = m_pos_y_reg;
    assign m_pos_z         = m_pos_z_reg;
    assign m_speed_limited = m_lim_reg;

endmodule

@@ dv/damped_spring_follower_top_tb.sv @@
// damped_spring_follower_top_tb: self-checking bench for the 3d spring-damper follower
// drives apb register writes and target beats, predicts each position beat in-line
// depends on dsf_pkg and damped_spring_follower_top
`timescale 1ns / 1ps

module damped_spring_follower_top_tb;

    localparam int REG_UNMAPPED = 6;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               lim;
    } pos_beat_t;

    typedef struct {
        logic               cmd;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic               typed;
        pos_beat_t          want;
    } target_row_t;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic               s_cmd;
    logic signed [31:0] s_target_x;
    logic signed [31:0] s_target_y;
    logic signed [31:0] s_target_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic signed [31:0] m_pos_z;
    logic               m_speed_limited;

    damped_spring_follower_top u_top (.*);

    // follower model state and register copy
    logic signed [31:0] fol_pos[3];
    logic signed [31:0] fol_vel[3];
    logic [31:0]        k_gain;
    logic [31:0]        c_gain;
    logic [31:0]        m_gain;
    logic [30:0]        vmax;
    logic [30:0]        sag;
    logic [15:0]        dt;

    pos_beat_t   expected_pos_q[$];
    target_row_t directed_rows[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          want_long_hold = 0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint scale_q16(input longint a, input longint unsigned b);
        longint unsigned mag;
        longint unsigned p;
        mag = (a < 0) ? -a : a;
        p = (mag * b) >> 16;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned gain_over_mass(input logic [31:0] g);
        longint unsigned m;
        longint unsigned q;
        m = (m_gain < dsf_pkg::MASS_FLOOR) ? 64'(dsf_pkg::MASS_FLOOR) : 64'(m_gain);
        q = (64'(g) << 16) / m;
        return (q > 64'hffffffff) ? 64'hffffffff : q;
    endfunction

    task automatic follow_step(input target_row_t row, output pos_beat_t r);
        logic signed [31:0] tgt[3];
        longint unsigned    km;
        longint unsigned    cm;
        longint unsigned    sumsq;
        longint unsigned    mag;
        longint unsigned    s;
        longint unsigned    q;
        longint             acc;
        tgt[0] = row.tx;
        tgt[1] = row.ty;
        tgt[2] = row.tz;
        r.lim = 1'b0;
        if (row.cmd) begin
            for (int i = 0; i < 3; i++) begin
                fol_pos[i] = tgt[i];
                fol_vel[i] = '0;
            end
            fol_pos[2] = clamp32(longint'(tgt[2]) - longint'(sag));
        end else begin
            km = gain_over_mass(k_gain);
            cm = gain_over_mass(c_gain);
            sumsq = 0;
            for (int i = 0; i < 3; i++) begin
                acc = scale_q16(clamp32(longint'(tgt[i]) - longint'(fol_pos[i])), km)
                    - scale_q16(longint'(fol_vel[i]), cm);
                fol_vel[i] = clamp32(longint'(fol_vel[i]) + scale_q16(acc, 64'(dt)));
            end
            for (int i = 0; i < 3; i++) begin
                mag = (fol_vel[i] < 0) ? -longint'(fol_vel[i]) : longint'(fol_vel[i]);
                sumsq += mag * mag;
            end
            if (vmax != 0 && sumsq > 64'(vmax) * 64'(vmax)) begin
                s = root_floor(sumsq);
                if (s == 0) s = 1;
                for (int i = 0; i < 3; i++) begin
                    mag = (fol_vel[i] < 0) ? -longint'(fol_vel[i]) : longint'(fol_vel[i]);
                    q = mag * 64'(vmax) / s;
                    fol_vel[i] = clamp32((fol_vel[i] < 0) ? -longint'(q) : longint'(q));
                end
                r.lim = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                fol_pos[i] = clamp32(longint'(fol_pos[i])
                                     + scale_q16(longint'(fol_vel[i]), 64'(dt)));
            end
            fol_pos[2] = clamp32(longint'(fol_pos[2]) - longint'(sag));
        end
        r.x = fol_pos[0];
        r.y = fol_pos[1];
        r.z = fol_pos[2];
    endtask

    task automatic reg_write(input int idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dsf_pkg::REG_STIFFNESS:   k_gain = val;
            dsf_pkg::REG_DAMPING:     c_gain = val;
            dsf_pkg::REG_MASS:        m_gain = val;
            dsf_pkg::REG_MAX_SPEED:   vmax = val[30:0];
            dsf_pkg::REG_GRAVITY_SAG: sag = val[30:0];
            dsf_pkg::REG_TIME_STEP:   dt = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] k, input logic [31:0] c, input logic [31:0] m,
                             input logic [31:0] v, input logic [31:0] g, input logic [31:0] t);
        reg_write(dsf_pkg::REG_STIFFNESS, k);
        reg_write(dsf_pkg::REG_DAMPING, c);
        reg_write(dsf_pkg::REG_MASS, m);
        reg_write(dsf_pkg::REG_MAX_SPEED, v);
        reg_write(dsf_pkg::REG_GRAVITY_SAG, g);
        reg_write(dsf_pkg::REG_TIME_STEP, t);
    endtask

    // called at a falling edge; leaves s_valid high after acceptance
    task automatic send_target(input target_row_t row);
        pos_beat_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= row.cmd;
        s_target_x <= row.tx;
        s_target_y <= row.ty;
        s_target_z <= row.tz;
        do @(posedge aclk); while (!s_ready);
        follow_step(row, r);
        expected_pos_q.push_back(row.typed ? row.want : r);
        @(negedge aclk);
    endtask

    task automatic add_row(input logic cmd, input logic [31:0] tx, input logic [31:0] ty,
                           input logic [31:0] tz, input logic typed, input logic [31:0] ex,
                           input logic [31:0] ey, input logic [31:0] ez);
        target_row_t row;
        row.cmd = cmd;
        row.tx = tx;
        row.ty = ty;
        row.tz = tz;
        row.typed = typed;
        row.want.x = ex;
        row.want.y = ey;
        row.want.z = ez;
        row.want.lim = 1'b0;
        directed_rows.push_back(row);
    endtask

    function automatic logic [31:0] pick_coord(input int sel, input logic signed [31:0] near);
        case (sel % 4)
            0: return $urandom();
            1: return near + $signed($urandom_range(2097152)) - 32'sd1048576;
            2: return near + $signed($urandom_range(65535)) - 32'sd32768;
            default: return ($urandom_range(1) != 0) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic target_row_t random_row();
        target_row_t row;
        int          r;
        int          sel;
        r = $urandom_range(99);
        row.typed = 1'b0;
        row.cmd = (r < 15);
        sel = (r < 70) ? 1 + (r % 2) : (r < 90) ? 0 : 3;
        row.tx = pick_coord(sel, fol_pos[0]);
        row.ty = pick_coord(sel, fol_pos[1]);
        row.tz = pick_coord(sel, fol_pos[2]);
        return row;
    endfunction

    task automatic drain();
        while (expected_pos_q.size() != 0) @(posedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // receiver side
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (want_long_hold && !hold_done) begin
                hold_left = 4000;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        pos_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pos_q.size() == 0) begin
                $error("unexpected position beat x=%0d y=%0d z=%0d", m_pos_x, m_pos_y, m_pos_z);
                mismatch_count++;
            end else begin
                e = expected_pos_q.pop_front();
                if (m_pos_x !== e.x) begin
                    $error("pos_x expected %0d got %0d", e.x, m_pos_x);
                    mismatch_count++;
                end
                if (m_pos_y !== e.y) begin
                    $error("pos_y expected %0d got %0d", e.y, m_pos_y);
                    mismatch_count++;
                end
                if (m_pos_z !== e.z) begin
                    $error("pos_z expected %0d got %0d", e.z, m_pos_z);
                    mismatch_count++;
                end
                if (m_speed_limited !== e.lim) begin
                    $error("speed_limited expected %0b got %0b", e.lim, m_speed_limited);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int idle_pat[4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{36, 36}};
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_cmd      = 1'b0;
        s_target_x = '0;
        s_target_y = '0;
        s_target_z = '0;
        k_gain = dsf_pkg::RST_STIFFNESS;
        c_gain = dsf_pkg::RST_DAMPING;
        m_gain = dsf_pkg::RST_MASS;
        vmax   = dsf_pkg::RST_MAX_SPEED;
        sag    = dsf_pkg::RST_GRAVITY_SAG;
        dt     = dsf_pkg::RST_TIME_STEP;
        for (int i = 0; i < 3; i++) begin
            fol_pos[i] = '0;
            fol_vel[i] = '0;
        end
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // directed: snaps with saturation, steps toward extremes
        add_row(1, 0, 0, 0, 1, 0, 0, 32'hfffff800);
        add_row(1, 32'h7fffffff, 32'h80000000, 32'h80000000, 1,
                32'h7fffffff, 32'h80000000, 32'h80000000);
        add_row(1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1,
                32'hffffffff, 32'hffffffff, 32'hfffff7ff);
        add_row(1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1,
                32'h80000000, 32'h7fffffff, 32'h7ffff7ff);
        add_row(0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
        add_row(0, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 1, 0, 0, 32'hfffff800);
        for (int i = 0; i < 16; i++) begin
            add_row(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
        end
        add_row(0, 0, 0, 0, 0, 0, 0, 0);
        foreach (directed_rows[i]) send_target(directed_rows[i]);

        for (int ph = 0; ph < 6; ph++) begin
            s_valid <= 1'b0;
            drain();
            case (ph)
                1: write_all(32'hffffffff, 32'hffffffff, 0, 32'hffffffff, 32'hffffffff,
                             32'hffffffff);
                2: write_all(0, 0, 42, 0, 0, 0);
                3: write_all(4 << 16, 2 << 16, 1 << 16, 20 << 12, 100, 4096);
                4: write_all($urandom(), $urandom(), $urandom(), $urandom_range(1 << 24),
                             $urandom_range(1 << 14), $urandom());
                5: begin
                    write_all(dsf_pkg::RST_STIFFNESS, dsf_pkg::RST_DAMPING, dsf_pkg::RST_MASS,
                              32'(dsf_pkg::RST_MAX_SPEED), 32'(dsf_pkg::RST_GRAVITY_SAG),
                              32'(dsf_pkg::RST_TIME_STEP));
                    reg_write(REG_UNMAPPED, 32'hffffffff);
                end
                default: ;
            endcase
            send_idle_pct  = idle_pat[ph % 4][0];
            recv_stall_pct = idle_pat[ph % 4][1];
            @(negedge aclk);
            for (int n = 0; n < 175; n++) begin
                if (ph == 0 && n == 20) want_long_hold = 1;
                send_target(random_row());
            end
        end
        s_valid <= 1'b0;
        while (expected_pos_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
